// ===== design/wim_pkg.sv =====
// types and constants shared by the windowed interval median block
// no dependencies; imported by wim_cell, wim_ctrl and the top level
`default_nettype none

package wim_pkg;

    localparam int TS_W      = 48;
    localparam int OCOUNT_W  = 7;
    localparam logic [OCOUNT_W-1:0] OCOUNT_MAX = 7'd127;

    // work register operation broadcast to every cell
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_LOAD,
        OP_SORT,
        OP_SHIFT
    } wim_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SORT,
        ST_SELECT,
        ST_DONE
    } wim_state_t;

    // controller to datapath
    typedef struct packed {
        wim_op_t op;
        logic    phase;        // parity of the current sort phase
        logic    hist_shift;   // new interval enters the history chain
        logic    ts_load;      // newest timestamp register takes the word
        logic    result_load;  // output register takes the median
        logic    busy;         // a query is in flight
    } wim_cmd_t;

endpackage

`default_nettype wire

// ===== design/wim_cell.sv =====
// one cell of the interval chain: a history register and a sort work register
// depends on wim_pkg; neighbors exchange data during sort and shift operations
`default_nettype none

module wim_cell (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire wim_pkg::wim_op_t        op,
    input  wire logic                    hist_shift,
    input  wire logic                    pair_right,
    input  wire logic                    pair_left,
    input  wire logic                    load_valid,
    input  wire logic [wim_pkg::TS_W-1:0] hist_in,
    input  wire logic [wim_pkg::TS_W-1:0] left_val,
    input  wire logic                    left_vld,
    input  wire logic [wim_pkg::TS_W-1:0] right_val,
    input  wire logic                    right_vld,
    output logic      [wim_pkg::TS_W-1:0] hist_out,
    output logic      [wim_pkg::TS_W-1:0] work_val,
    output logic                         work_vld
);
    import wim_pkg::*;

    logic [TS_W-1:0] hist_reg;
    logic [TS_W-1:0] work_reg;
    logic [TS_W-1:0] work_next;
    logic            vld_reg;
    logic            vld_next;
    logic [TS_W-1:0] partner_val;
    logic            partner_vld;
    logic            partner_lt;

    assign partner_val = pair_right ? right_val : left_val;
    assign partner_vld = pair_right ? right_vld : left_vld;
    // an empty slot sorts above everything
    assign partner_lt  = partner_vld && (!vld_reg || (partner_val < work_reg));

    always_comb
    begin
        work_next = work_reg;
        vld_next  = vld_reg;
        unique case (op)
            OP_HOLD:
            begin
                work_next = work_reg;
                vld_next  = vld_reg;
            end
            OP_LOAD:
            begin
                work_next = hist_reg;
                vld_next  = load_valid;
            end
            OP_SORT:
            begin
                // lower cell of a pair keeps the min, upper keeps the max
                if (pair_right)
                begin
                    work_next = partner_lt ? partner_val : work_reg;
                    vld_next  = partner_lt ? partner_vld : vld_reg;
                end
                else if (pair_left)
                begin
                    work_next = partner_lt ? work_reg : partner_val;
                    vld_next  = partner_lt ? vld_reg  : partner_vld;
                end
            end
            OP_SHIFT:
            begin
                work_next = right_val;
                vld_next  = right_vld;
            end
            default:
            begin
                work_next = work_reg;
                vld_next  = vld_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (hist_shift)
        begin
            hist_reg <= hist_in;
        end
        work_reg <= work_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign hist_out = hist_reg;
    assign work_val = work_reg;
    assign work_vld = vld_reg;

endmodule

`default_nettype wire

// ===== design/wim_ctrl.sv =====
// sequencer for records and queries: fill tracking, sort phases, median shift-out
// depends on wim_pkg; drives the cell chain through a wim_cmd_t
`default_nettype none

module wim_ctrl #(
    parameter int WINDOW = 128
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  wire logic                       in_query,
    input  wire logic                       out_free,
    output logic                            in_ready,
    output wim_pkg::wim_cmd_t               cmd,
    output logic      [$clog2(WINDOW)-1:0]  count
);
    import wim_pkg::*;

    localparam int N     = WINDOW - 1;
    localparam int CNT_W = $clog2(WINDOW);
    localparam logic [CNT_W-1:0] LAST_PHASE = CNT_W'(N - 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(N);

    wim_state_t       state_reg;
    wim_state_t       state_next;
    logic             have_ts_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] phase_reg;
    logic [CNT_W-1:0] shift_reg;
    logic             accept;
    logic             accept_record;
    logic             accept_query;

    // ready depends on the state alone
    assign in_ready      = (state_reg == ST_IDLE);
    assign accept        = in_valid && in_ready;
    assign accept_record = accept && !in_query;
    assign accept_query  = accept && in_query;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_query)
                begin
                    state_next = ST_SORT;
                end
            end
            ST_SORT:
            begin
                if (phase_reg == LAST_PHASE)
                begin
                    state_next = ST_SELECT;
                end
            end
            ST_SELECT:
            begin
                if (shift_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.op          = OP_HOLD;
        cmd.phase       = phase_reg[0];
        cmd.hist_shift  = 1'b0;
        cmd.ts_load     = 1'b0;
        cmd.result_load = 1'b0;
        cmd.busy        = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.busy       = 1'b0;
                cmd.ts_load    = accept_record;
                cmd.hist_shift = accept_record && have_ts_reg;
                cmd.op         = accept_query ? OP_LOAD : OP_HOLD;
            end
            ST_SORT:
            begin
                cmd.op = OP_SORT;
            end
            ST_SELECT:
            begin
                cmd.op = (shift_reg != '0) ? OP_SHIFT : OP_HOLD;
            end
            ST_DONE:
            begin
                cmd.result_load = out_free;
            end
            default:
            begin
                cmd.op = OP_HOLD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            have_ts_reg <= 1'b0;
            count_reg   <= '0;
            phase_reg   <= '0;
            shift_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept_record)
            begin
                have_ts_reg <= 1'b1;
                if (have_ts_reg && (count_reg != FULL_COUNT))
                begin
                    count_reg <= count_reg + 1'b1;
                end
            end
            if (accept_query)
            begin
                phase_reg <= '0;
                shift_reg <= count_reg >> 1;
            end
            else if (state_reg == ST_SORT)
            begin
                phase_reg <= phase_reg + 1'b1;
            end
            else if ((state_reg == ST_SELECT) && (shift_reg != '0))
            begin
                shift_reg <= shift_reg - 1'b1;
            end
        end
    end

    assign count = count_reg;

endmodule

`default_nettype wire

// ===== design/windowed_interval_median_unit.sv =====
// channel | dir | tdata (low bit up)                         | tuser
// s_*     | in  | timestamp[47:0]                            | command (1 = query)
// m_*     | out | median_interval[47:0], interval_count[54:48] | has_median
//
// a record leaves the input ready
// a query runs through load, odd-even transposition sort over the cell chain,
// median shifted down to cell zero, and output
// m_tready low with a word pending holds a finished query in the last step and the input not ready
// reset clears fill tracking and control; timestamps and intervals are not reset
// depends on wim_pkg, wim_ctrl, wim_cell
`default_nettype none

module windowed_interval_median_unit #(
    parameter int WINDOW = 128
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // timestamp
    input  wire logic        s_tuser,   // command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [55:0] m_tdata,   // median_interval, interval_count, pad
    output logic             m_tuser    // has_median
);
    import wim_pkg::*;

    localparam int N     = WINDOW - 1;
    localparam int CNT_W = $clog2(WINDOW);
    localparam int CMP_W = (CNT_W > OCOUNT_W) ? CNT_W : OCOUNT_W;

    wim_cmd_t         cmd;
    logic [CNT_W-1:0] count;
    logic             out_free;

    logic [TS_W-1:0]  newest_ts_reg;
    logic [TS_W-1:0]  new_interval;

    logic [TS_W-1:0]  hist_out [N];
    logic [TS_W-1:0]  work_val [N];
    logic             work_vld [N];

    logic             m_valid_reg;
    logic [TS_W-1:0]  median_reg;
    logic [OCOUNT_W-1:0] ocount_reg;
    logic             has_reg;
    logic [OCOUNT_W-1:0] ocount_next;

    assign out_free = !m_valid_reg || m_tready;

    wim_ctrl #(
        .WINDOW (WINDOW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_query (s_tuser),
        .out_free (out_free),
        .in_ready (s_tready),
        .cmd      (cmd),
        .count    (count)
    );

    // wraps modulo 2^48
    assign new_interval = s_tdata - newest_ts_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.ts_load)
        begin
            newest_ts_reg <= s_tdata;
        end
    end

    generate
        for (genvar k = 0; k < N; k++)
        begin : g_cell
            localparam bit KODD = (k % 2) == 1;
            logic            pair_right;
            logic            pair_left;
            logic            load_valid;
            logic [TS_W-1:0] hist_in;
            logic [TS_W-1:0] left_val;
            logic            left_vld;
            logic [TS_W-1:0] right_val;
            logic            right_vld;

            assign pair_right = (cmd.phase == KODD) && (k + 1 < N);
            assign pair_left  = (k > 0) && (cmd.phase != KODD);
            assign load_valid = CNT_W'(k) < count;

            if (k == 0)
            begin : g_head
                assign hist_in  = new_interval;
                assign left_val = '0;
                assign left_vld = 1'b0;
            end
            else
            begin : g_body
                assign hist_in  = hist_out[k-1];
                assign left_val = work_val[k-1];
                assign left_vld = work_vld[k-1];
            end

            if (k == N - 1)
            begin : g_tail
                assign right_val = '0;
                assign right_vld = 1'b0;
            end
            else
            begin : g_next
                assign right_val = work_val[k+1];
                assign right_vld = work_vld[k+1];
            end

            wim_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .op         (cmd.op),
                .hist_shift (cmd.hist_shift),
                .pair_right (pair_right),
                .pair_left  (pair_left),
                .load_valid (load_valid),
                .hist_in    (hist_in),
                .left_val   (left_val),
                .left_vld   (left_vld),
                .right_val  (right_val),
                .right_vld  (right_vld),
                .hist_out   (hist_out[k]),
                .work_val   (work_val[k]),
                .work_vld   (work_vld[k])
            );
        end
    endgenerate

    // interval count saturates at the field maximum
    always_comb
    begin
        if (CMP_W'(count) > CMP_W'(OCOUNT_MAX))
        begin
            ocount_next = OCOUNT_MAX;
        end
        else
        begin
            ocount_next = OCOUNT_W'(count);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
        begin
            median_reg <= work_vld[0] ? work_val[0] : '0;
            ocount_reg <= ocount_next;
            has_reg    <= work_vld[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (cmd.result_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, ocount_reg, median_reg};
    assign m_tuser  = has_reg;

    // flag and count agree on every result word
    a_has_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == (m_tdata[54:48] != '0)))
        else $error("has_median disagrees with interval_count");

    // the history chain moves only on an accepted record
    a_hist_on_record: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.hist_shift |-> (s_tvalid && s_tready && !s_tuser))
        else $error("history chain shifted without a record");

    // no input is taken while a query is in flight
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.busy |-> !s_tready)
        else $error("input ready during a query");

    // a result is loaded only when the output register can take it
    a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.result_load |-> (!m_tvalid || m_tready))
        else $error("result overwrote a pending word");

endmodule

`default_nettype wire
